[sv/rmc_pkg.sv]
package rmc_pkg;

  // field buffer depth and derived widths
  localparam int FIELD_CHARS = 6;
  localparam int CNT_W       = $clog2(FIELD_CHARS + 1);
  localparam int IDX_W       = $clog2(FIELD_CHARS);
  localparam int VAL_W       = 7;
  localparam int OFF_W       = 5;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // offset register reset and clamp
  localparam logic [OFF_W-1:0] OFF_RESET = 5'd3;
  localparam logic [OFF_W-1:0] OFF_MAX   = 5'd23;

  // calendar constants
  localparam logic [VAL_W-1:0] HOURS_DAY  = 7'd24;
  localparam logic [VAL_W-1:0] MONTH_DEC  = 7'd12;
  localparam logic [VAL_W-1:0] MONTH_FEB  = 7'd2;
  localparam logic [VAL_W-1:0] YEAR_LAST  = 7'd99;
  localparam logic [VAL_W-1:0] DAYS_LONG  = 7'd31;
  localparam logic [VAL_W-1:0] DAYS_LEAPF = 7'd29;

  // sentence walker states
  typedef enum logic [4:0] {
    ST_WAIT_R,
    ST_WAIT_M,
    ST_WAIT_C,
    ST_COMMA1,
    ST_TIME,
    ST_COMMA2,
    ST_VALID,
    ST_LAT,
    ST_LAT_POLE,
    ST_LON,
    ST_LON_POLE,
    ST_SPEED,
    ST_COMMA8,
    ST_COURSE,
    ST_COMMA9,
    ST_DATE,
    ST_EMIT
  } parse_state_t;

  // decoded time and date of one sentence
  typedef struct packed {
    logic             fix;
    logic             err;
    logic [VAL_W-1:0] hh;
    logic [VAL_W-1:0] mi;
    logic [VAL_W-1:0] ss;
    logic [VAL_W-1:0] dd;
    logic [VAL_W-1:0] mo;
    logic [VAL_W-1:0] yy;
  } rmc_fields_t;

  // parser to pipeline hand-off
  typedef struct packed {
    logic        emit;
    rmc_fields_t fields;
  } rmc_emit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // two ascii characters to a value, non-digits read as zero
  function automatic logic [VAL_W-1:0] pair_value(input logic [7:0] hi_c,
                                                   input logic [7:0] lo_c);
    logic [3:0] hv;
    logic [3:0] lv;
    hv = is_digit(hi_c) ? hi_c[3:0] : 4'd0;
    lv = is_digit(lo_c) ? lo_c[3:0] : 4'd0;
    return ({3'b000, hv} << 3) + ({3'b000, hv} << 1) + {3'b000, lv};
  endfunction

  // days of a month 1..12
  function automatic logic [VAL_W-1:0] month_days(input logic [3:0] mo);
    logic [VAL_W-1:0] d;
    unique case (mo)
      4'd2:                      d = 7'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 7'd30;
      default:                   d = DAYS_LONG;
    endcase
    return d;
  endfunction

endpackage

[sv/rmc_if.sv]
// input byte channel
interface rmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// result channel
interface rmc_out_if;
  logic       valid;
  logic       ready;
  logic       fix_valid;
  logic       format_error;
  logic [6:0] hours;
  logic [6:0] minutes;
  logic [6:0] seconds;
  logic [6:0] day;
  logic [6:0] month;
  logic [6:0] year;

  modport source (output valid, output fix_valid, output format_error, output hours,
                  output minutes, output seconds, output day, output month,
                  output year, input ready);
  modport sink   (input valid, input fix_valid, input format_error, input hours,
                  input minutes, input seconds, input day, input month,
                  input year, output ready);
endinterface

[sv/rmc_parse.sv]
module rmc_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  output rmc_pkg::rmc_emit_t emit_o
);

  rmc_pkg::parse_state_t state_r, state_nxt;

  logic [7:0]                time_chars_r [rmc_pkg::FIELD_CHARS];
  logic [7:0]                date_chars_r [rmc_pkg::FIELD_CHARS];
  logic [rmc_pkg::CNT_W-1:0] time_count_r;
  logic [rmc_pkg::CNT_W-1:0] date_count_r;
  logic [7:0]                validity_char_r;
  logic                      validity_seen_r;

  logic comma;
  logic dot;
  logic time_room;
  logic date_room;
  logic time_wr, date_wr, valid_wr;
  logic time_cnt_clr, date_cnt_clr, seen_clr;
  logic emit;

  assign comma     = (in_byte == rmc_pkg::CH_COMMA);
  assign dot       = (in_byte == rmc_pkg::CH_DOT);
  assign time_room = (time_count_r < rmc_pkg::CNT_W'(rmc_pkg::FIELD_CHARS));
  assign date_room = (date_count_r < rmc_pkg::CNT_W'(rmc_pkg::FIELD_CHARS));

  // next state
  always_comb begin
    state_nxt = state_r;
    if (in_fire) begin
      unique case (state_r)
        rmc_pkg::ST_WAIT_R:   if (in_byte == rmc_pkg::CH_R) state_nxt = rmc_pkg::ST_WAIT_M;
        rmc_pkg::ST_WAIT_M:   if (in_byte == rmc_pkg::CH_M) state_nxt = rmc_pkg::ST_WAIT_C;
        rmc_pkg::ST_WAIT_C:   if (in_byte == rmc_pkg::CH_C) state_nxt = rmc_pkg::ST_COMMA1;
        rmc_pkg::ST_COMMA1:   if (comma) state_nxt = rmc_pkg::ST_TIME;
        rmc_pkg::ST_TIME: begin
          if (comma) state_nxt = rmc_pkg::ST_VALID;
          else if (dot) state_nxt = rmc_pkg::ST_COMMA2;
        end
        rmc_pkg::ST_COMMA2:   if (comma) state_nxt = rmc_pkg::ST_VALID;
        rmc_pkg::ST_VALID:    if (comma) state_nxt = rmc_pkg::ST_LAT;
        rmc_pkg::ST_LAT:      if (comma) state_nxt = rmc_pkg::ST_LAT_POLE;
        rmc_pkg::ST_LAT_POLE: if (comma) state_nxt = rmc_pkg::ST_LON;
        rmc_pkg::ST_LON:      if (comma) state_nxt = rmc_pkg::ST_LON_POLE;
        rmc_pkg::ST_LON_POLE: if (comma) state_nxt = rmc_pkg::ST_SPEED;
        rmc_pkg::ST_SPEED:
          state_nxt = comma ? rmc_pkg::ST_COURSE : rmc_pkg::ST_COMMA8;
        rmc_pkg::ST_COMMA8:   if (comma) state_nxt = rmc_pkg::ST_COURSE;
        rmc_pkg::ST_COURSE:
          state_nxt = comma ? rmc_pkg::ST_DATE : rmc_pkg::ST_COMMA9;
        rmc_pkg::ST_COMMA9:   if (comma) state_nxt = rmc_pkg::ST_DATE;
        rmc_pkg::ST_DATE:     if (comma) state_nxt = rmc_pkg::ST_EMIT;
        rmc_pkg::ST_EMIT:     state_nxt = rmc_pkg::ST_WAIT_R;
        default:              state_nxt = rmc_pkg::ST_WAIT_R;
      endcase
    end
  end

  // buffer controls
  always_comb begin
    time_wr      = 1'b0;
    date_wr      = 1'b0;
    valid_wr     = 1'b0;
    time_cnt_clr = 1'b0;
    date_cnt_clr = 1'b0;
    seen_clr     = 1'b0;
    emit         = 1'b0;
    if (in_fire) begin
      unique case (state_r)
        rmc_pkg::ST_COMMA1: time_cnt_clr = 1'b1;
        rmc_pkg::ST_TIME: begin
          seen_clr = 1'b1;
          time_wr  = !comma && !dot && time_room;
        end
        rmc_pkg::ST_VALID: valid_wr = !comma && !validity_seen_r;
        rmc_pkg::ST_COMMA9: date_cnt_clr = 1'b1;
        rmc_pkg::ST_DATE: date_wr = !comma && date_room;
        rmc_pkg::ST_EMIT: emit = 1'b1;
        default: ;
      endcase
    end
  end

  // state and field buffers
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      state_r         <= rst_n ? state_nxt : rmc_pkg::ST_WAIT_R;
      time_count_r    <= '0;
      date_count_r    <= '0;
      validity_char_r <= '0;
      validity_seen_r <= 1'b0;
      for (int i = 0; i < rmc_pkg::FIELD_CHARS; i++) begin
        time_chars_r[i] <= '0;
        date_chars_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (time_cnt_clr) time_count_r <= '0;
      else if (time_wr) begin
        time_chars_r[time_count_r[rmc_pkg::IDX_W-1:0]] <= in_byte;
        time_count_r <= time_count_r + 1'b1;
      end
      if (date_cnt_clr) date_count_r <= '0;
      else if (date_wr) begin
        date_chars_r[date_count_r[rmc_pkg::IDX_W-1:0]] <= in_byte;
        date_count_r <= date_count_r + 1'b1;
      end
      if (seen_clr) validity_seen_r <= 1'b0;
      else if (valid_wr) begin
        validity_char_r <= in_byte;
        validity_seen_r <= 1'b1;
      end
    end
  end

  // digit decode of the stored characters
  logic err_any;
  always_comb begin
    err_any = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (!rmc_pkg::is_digit(time_chars_r[i]) || !rmc_pkg::is_digit(date_chars_r[i]))
        err_any = 1'b1;
    end
  end

  assign emit_o.emit       = emit;
  assign emit_o.fields.fix = (validity_char_r == rmc_pkg::CH_A);
  assign emit_o.fields.err = err_any;
  assign emit_o.fields.hh  = rmc_pkg::pair_value(time_chars_r[0], time_chars_r[1]);
  assign emit_o.fields.mi  = rmc_pkg::pair_value(time_chars_r[2], time_chars_r[3]);
  assign emit_o.fields.ss  = rmc_pkg::pair_value(time_chars_r[4], time_chars_r[5]);
  assign emit_o.fields.dd  = rmc_pkg::pair_value(date_chars_r[0], date_chars_r[1]);
  assign emit_o.fields.mo  = rmc_pkg::pair_value(date_chars_r[2], date_chars_r[3]);
  assign emit_o.fields.yy  = rmc_pkg::pair_value(date_chars_r[4], date_chars_r[5]);

endmodule

[sv/rmc_adjust.sv]
module rmc_adjust (
  input  rmc_pkg::rmc_fields_t      raw,
  input  logic [rmc_pkg::OFF_W-1:0] offset,
  output rmc_pkg::rmc_fields_t      adj
);

  logic [rmc_pkg::OFF_W-1:0] off;
  logic [rmc_pkg::VAL_W-1:0] off_w;
  logic [rmc_pkg::VAL_W-1:0] hh, dd, mo, yy;

  // clamp the offset to a day
  assign off   = (offset > rmc_pkg::OFF_MAX) ? rmc_pkg::OFF_MAX : offset;
  assign off_w = {2'b00, off};

  // local time with day, month and year rollback
  always_comb begin
    hh = raw.hh;
    dd = raw.dd;
    mo = raw.mo;
    yy = raw.yy;
    if (raw.fix) begin
      if (raw.hh >= off_w) begin
        hh = raw.hh - off_w;
      end else begin
        hh = raw.hh + rmc_pkg::HOURS_DAY - off_w;
        if (raw.dd > 7'd1) begin
          dd = raw.dd - 7'd1;
        end else begin
          if (raw.mo <= 7'd1) begin
            mo = rmc_pkg::MONTH_DEC;
            yy = (raw.yy == '0) ? rmc_pkg::YEAR_LAST : raw.yy - 7'd1;
          end else begin
            mo = raw.mo - 7'd1;
          end
          dd = (mo <= rmc_pkg::MONTH_DEC) ? rmc_pkg::month_days(mo[3:0])
                                          : rmc_pkg::DAYS_LONG;
          // two-digit year: multiple of four is leap, 00 included
          if (mo == rmc_pkg::MONTH_FEB && yy[1:0] == 2'b00) dd = rmc_pkg::DAYS_LEAPF;
        end
      end
    end
  end

  assign adj.fix = raw.fix;
  assign adj.err = raw.err;
  assign adj.hh  = hh;
  assign adj.mi  = raw.mi;
  assign adj.ss  = raw.ss;
  assign adj.dd  = dd;
  assign adj.mo  = mo;
  assign adj.yy  = yy;

endmodule

[sv/nmea_rmc_time_date_parser_top.sv]
// NMEA RMC time and date parser.
// in_ch carries one received character per word; the parser walks the RMC
// sentence, keeps the time, validity letter and date fields, and on the
// character after the comma that closes the date field puts one word on
// out_ch: time, date, fix_valid and format_error. With validity letter A the
// time is moved back by cfg_wdata hours (written with cfg_we, clamped to 23)
// with day, month and year rollback.
// Throughput: one character per cycle while in_ch.ready is high. The emitting
// character is registered with the decoded fields in a stage register, the
// rollback logic sits between that stage and the output register, so a result
// passes the stage register and then the output register on its way to out_ch.
// When out_ch stalls, the output register and the stage register both hold a
// result; in_ch.ready drops only while both are full and out_ch is stalled.
// Characters that produce no result are still taken while either stage has room.
// Reset (rst_n low, synchronous) clears both stages, returns the parser to
// waiting for R, clears the field buffers and sets the offset to 3 hours.
module nmea_rmc_time_date_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  rmc_in_if.sink      in_ch,
  rmc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  logic [rmc_pkg::OFF_W-1:0] offset_r;
  rmc_pkg::rmc_emit_t        emit_w;
  rmc_pkg::rmc_fields_t      s1_fields_r;
  logic                      s1_valid_r;
  rmc_pkg::rmc_fields_t      adj_w;
  rmc_pkg::rmc_fields_t      out_fields_r;
  logic                      out_valid_r;
  logic                      out_free;
  logic                      in_fire;

  // handshakes
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // offset register
  always_ff @(posedge clk) begin
    if (!rst_n) offset_r <= rmc_pkg::OFF_RESET;
    else if (cfg_we) offset_r <= cfg_wdata;
  end

  // sentence walker
  rmc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_ch.data_byte),
    .emit_o  (emit_w)
  );

  // stage register for decoded fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (emit_w.emit) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_w.emit) s1_fields_r <= emit_w.fields;
  end

  // local time rollback
  rmc_adjust u_adjust (
    .raw    (s1_fields_r),
    .offset (offset_r),
    .adj    (adj_w)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) out_fields_r <= adj_w;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.fix_valid    = out_fields_r.fix;
  assign out_ch.format_error = out_fields_r.err;
  assign out_ch.hours        = out_fields_r.hh;
  assign out_ch.minutes      = out_fields_r.mi;
  assign out_ch.seconds      = out_fields_r.ss;
  assign out_ch.day          = out_fields_r.dd;
  assign out_ch.month        = out_fields_r.mo;
  assign out_ch.year         = out_fields_r.yy;

  // a closing character always lands in the stage register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit_w.emit |=> s1_valid_r)
    else $error("emitted result not captured");

  // a staged result moves to the output when the output has room
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free) |=> out_valid_r)
    else $error("staged result lost");

  // an emit is only possible when the stage can take it
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit_w.emit |-> (!s1_valid_r || out_free))
    else $error("stage register overrun");

  // a stalled result keeps its fields
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_fields_r))
    else $error("stalled result changed");

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_WORDS  = 370;
  localparam int SETTLE_CYCLES = 6;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [rmc_pkg::OFF_W-1:0] cfg_wdata;
  logic                      sink_ready = 1'b0;

  rmc_in_if  in_ch ();
  rmc_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  nmea_rmc_time_date_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // pacing controls for the input and result sides
  bit no_gaps      = 1'b0;
  bit hold_results = 1'b0;
  int sink_stall   = 0;

  // sentence walker mirror
  rmc_pkg::parse_state_t     walk_state;
  logic [7:0]                time_buf [rmc_pkg::FIELD_CHARS];
  logic [7:0]                date_buf [rmc_pkg::FIELD_CHARS];
  int unsigned               time_len;
  int unsigned               date_len;
  logic [7:0]                fix_letter;
  logic                      fix_letter_seen;
  logic [rmc_pkg::OFF_W-1:0] offset_hours;
  rmc_pkg::rmc_fields_t      pending_stamps [$];
  int days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // run statistics
  int words_taken      = 0;
  int words_in_lines   = 0;
  int stamps_predicted = 0;
  int stamps_checked   = 0;
  int stamps_shifted   = 0;
  int stamps_malformed = 0;
  int offsets_written  = 0;
  int mismatches       = 0;

  // sentence under construction
  logic [7:0] line_buf [$];

  function automatic void clear_sentence();
    for (int i = 0; i < rmc_pkg::FIELD_CHARS; i++) begin
      time_buf[i] = 8'h00;
      date_buf[i] = 8'h00;
    end
    time_len        = 0;
    date_len        = 0;
    fix_letter      = 8'h00;
    fix_letter_seen = 1'b0;
  endfunction

  // two ascii characters to a number, anything but a digit reads as zero
  function automatic int digit_pair(input logic [7:0] hi_c, input logic [7:0] lo_c,
                                    inout logic bad);
    int v;
    v = 0;
    if (hi_c >= rmc_pkg::CH_0 && hi_c <= rmc_pkg::CH_9)
      v = 10 * (int'(hi_c) - int'(rmc_pkg::CH_0));
    else bad = 1'b1;
    if (lo_c >= rmc_pkg::CH_0 && lo_c <= rmc_pkg::CH_9)
      v = v + int'(lo_c) - int'(rmc_pkg::CH_0);
    else bad = 1'b1;
    return v;
  endfunction

  // decoded time and date, moved back by the offset on a valid fix
  function automatic rmc_pkg::rmc_fields_t decode_stamp();
    rmc_pkg::rmc_fields_t s;
    logic                 bad;
    int                   hh, mi, ss, dd, mo, yy, off;
    bad = 1'b0;
    hh  = digit_pair(time_buf[0], time_buf[1], bad);
    mi  = digit_pair(time_buf[2], time_buf[3], bad);
    ss  = digit_pair(time_buf[4], time_buf[5], bad);
    dd  = digit_pair(date_buf[0], date_buf[1], bad);
    mo  = digit_pair(date_buf[2], date_buf[3], bad);
    yy  = digit_pair(date_buf[4], date_buf[5], bad);
    s.fix = (fix_letter == rmc_pkg::CH_A);
    if (s.fix) begin
      off = (offset_hours > rmc_pkg::OFF_MAX) ? int'(rmc_pkg::OFF_MAX) : int'(offset_hours);
      if (hh >= off) begin
        hh = hh - off;
      end else begin
        hh = hh + 24 - off;
        if (dd > 1) begin
          dd = dd - 1;
        end else begin
          // previous month, wrapping into december of the previous year
          if (mo <= 1) begin
            mo = 12;
            yy = (yy == 0) ? 99 : yy - 1;
          end else begin
            mo = mo - 1;
          end
          dd = (mo <= 12) ? days_in_month[mo - 1] : 31;
          if (mo == 2 && (((yy % 4) == 0 && (yy % 100) != 0) || (yy % 400) == 0)) dd = 29;
        end
      end
    end
    s.err = bad;
    s.hh  = hh[6:0];
    s.mi  = mi[6:0];
    s.ss  = ss[6:0];
    s.dd  = dd[6:0];
    s.mo  = mo[6:0];
    s.yy  = yy[6:0];
    return s;
  endfunction

  // advance the walker by one character, returns 1 when a stamp comes out
  function automatic logic track_byte(input logic [7:0] c,
                                      output rmc_pkg::rmc_fields_t stamp);
    logic comma;
    logic fired;
    comma = (c == rmc_pkg::CH_COMMA);
    fired = 1'b0;
    stamp = '0;
    case (walk_state)
      rmc_pkg::ST_WAIT_R: if (c == rmc_pkg::CH_R) walk_state = rmc_pkg::ST_WAIT_M;
      rmc_pkg::ST_WAIT_M: if (c == rmc_pkg::CH_M) walk_state = rmc_pkg::ST_WAIT_C;
      rmc_pkg::ST_WAIT_C: if (c == rmc_pkg::CH_C) walk_state = rmc_pkg::ST_COMMA1;
      rmc_pkg::ST_COMMA1: begin
        time_len = 0;
        if (comma) walk_state = rmc_pkg::ST_TIME;
      end
      rmc_pkg::ST_TIME: begin
        fix_letter_seen = 1'b0;
        if (comma) begin
          walk_state = rmc_pkg::ST_VALID;
        end else if (c == rmc_pkg::CH_DOT) begin
          walk_state = rmc_pkg::ST_COMMA2;
        end else if (time_len < rmc_pkg::FIELD_CHARS) begin
          time_buf[time_len] = c;
          time_len++;
        end
      end
      rmc_pkg::ST_COMMA2: if (comma) walk_state = rmc_pkg::ST_VALID;
      rmc_pkg::ST_VALID: begin
        if (comma) begin
          walk_state = rmc_pkg::ST_LAT;
        end else if (!fix_letter_seen) begin
          fix_letter      = c;
          fix_letter_seen = 1'b1;
        end
      end
      rmc_pkg::ST_LAT:      if (comma) walk_state = rmc_pkg::ST_LAT_POLE;
      rmc_pkg::ST_LAT_POLE: if (comma) walk_state = rmc_pkg::ST_LON;
      rmc_pkg::ST_LON:      if (comma) walk_state = rmc_pkg::ST_LON_POLE;
      rmc_pkg::ST_LON_POLE: if (comma) walk_state = rmc_pkg::ST_SPEED;
      rmc_pkg::ST_SPEED:
        walk_state = comma ? rmc_pkg::ST_COURSE : rmc_pkg::ST_COMMA8;
      rmc_pkg::ST_COMMA8:   if (comma) walk_state = rmc_pkg::ST_COURSE;
      rmc_pkg::ST_COURSE:
        walk_state = comma ? rmc_pkg::ST_DATE : rmc_pkg::ST_COMMA9;
      rmc_pkg::ST_COMMA9: begin
        date_len = 0;
        if (comma) walk_state = rmc_pkg::ST_DATE;
      end
      rmc_pkg::ST_DATE: begin
        if (comma) begin
          walk_state = rmc_pkg::ST_EMIT;
        end else if (date_len < rmc_pkg::FIELD_CHARS) begin
          date_buf[date_len] = c;
          date_len++;
        end
      end
      rmc_pkg::ST_EMIT: begin
        stamp = decode_stamp();
        clear_sentence();
        walk_state = rmc_pkg::ST_WAIT_R;
        fired      = 1'b1;
      end
      default: walk_state = rmc_pkg::ST_WAIT_R;
    endcase
    return fired;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // watch both channels, predict on taken words, compare on result words
  always @(posedge clk) begin : word_monitor
    rmc_pkg::rmc_fields_t stamp;
    rmc_pkg::rmc_fields_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        words_taken++;
        if (track_byte(in_ch.data_byte, stamp)) begin
          pending_stamps.push_back(stamp);
          stamps_predicted++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_stamps.size() == 0) begin
          $error("result word with no stamp pending");
          mismatches++;
        end else begin
          want = pending_stamps.pop_front();
          stamps_checked++;
          if (want.fix) stamps_shifted++;
          if (want.err) stamps_malformed++;
          check_field("fix_valid", int'(want.fix), int'(out_ch.fix_valid));
          check_field("format_error", int'(want.err), int'(out_ch.format_error));
          check_field("hours", int'(want.hh), int'(out_ch.hours));
          check_field("minutes", int'(want.mi), int'(out_ch.minutes));
          check_field("seconds", int'(want.ss), int'(out_ch.seconds));
          check_field("day", int'(want.dd), int'(out_ch.day));
          check_field("month", int'(want.mo), int'(out_ch.month));
          check_field("year", int'(want.yy), int'(out_ch.year));
        end
      end
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause(input int longest);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, longest);
  endfunction

  // result side stalls
  always @(posedge clk) begin : result_pacing
    int pause;
    if (hold_results) begin
      sink_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_ready <= 1'b0;
      sink_stall--;
    end else begin
      pause = pick_pause(70);
      sink_ready <= (pause == 0);
      sink_stall = (pause > 0) ? pause - 1 : 0;
    end
  end

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = pick_pause(20);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and let every pending stamp come out
  task automatic wait_for_stamps();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_offset(input logic [rmc_pkg::OFF_W-1:0] hours);
    wait_for_stamps();
    cfg_wdata <= hours;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we       <= 1'b0;
    offset_hours = hours;
    offsets_written++;
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // any character that is not a digit and does not end a field
  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= rmc_pkg::CH_0 && c <= rmc_pkg::CH_9) || c == rmc_pkg::CH_COMMA ||
           c == rmc_pkg::CH_DOT);
    return c;
  endfunction

  // one rmc sentence, optionally with filled position fields and a bad character
  function automatic void build_rmc(input string head, input string tfield,
                                    input string vfield, input string dfield,
                                    input bit fill, input int t_bad, input int d_bad,
                                    input logic [7:0] closer);
    int at;
    add_text(head);
    at = line_buf.size();
    add_text(tfield);
    if (t_bad >= 0 && t_bad < tfield.len()) line_buf[at + t_bad] = odd_char();
    add_text({",", vfield, ","});
    if (fill) begin
      if ($urandom_range(0, 3) != 0)
        add_text($sformatf("%04d.%03d", $urandom_range(0, 9999), $urandom_range(0, 999)));
      add_text($urandom_range(0, 1) ? ",N," : ",S,");
      if ($urandom_range(0, 3) != 0)
        add_text($sformatf("%05d.%03d", $urandom_range(0, 99999), $urandom_range(0, 999)));
      add_text($urandom_range(0, 1) ? ",E," : ",W,");
      if ($urandom_range(0, 2) != 0)
        add_text($sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 9)));
      add_text(",");
      if ($urandom_range(0, 2) != 0)
        add_text($sformatf("%03d.%0d", $urandom_range(0, 359), $urandom_range(0, 9)));
      add_text(",");
    end else begin
      add_text(",,,,,,");
    end
    at = line_buf.size();
    add_text(dfield);
    if (d_bad >= 0 && d_bad < dfield.len()) line_buf[at + d_bad] = odd_char();
    add_text(",");
    line_buf.push_back(closer);
    if (fill) add_text($sformatf("*%02X\r\n", $urandom_range(0, 255)));
  endfunction

  task automatic send_line(input int keep);
    for (int i = 0; i < keep && i < line_buf.size(); i++) begin
      send_word(line_buf[i]);
      words_in_lines++;
    end
    line_buf.delete();
  endtask

  task automatic send_rmc(input string head, input string tfield, input string vfield,
                          input string dfield, input logic [7:0] closer);
    build_rmc(head, tfield, vfield, dfield, 1'b0, -1, -1, closer);
    send_line(line_buf.size());
  endtask

  // six digits from three pairs, sometimes cut short or overlong
  function automatic string digit_field(input int a, input int b, input int c);
    string full;
    string s;
    int    n;
    full = $sformatf("%02d%02d%02d", a, b, c);
    if ($urandom_range(0, 99) < 80) return full;
    n = $urandom_range(0, 9);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i < 6) s = {s, full.substr(i, i)};
      else s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    return s;
  endfunction

  task automatic send_random_sentence(input bit cut_short);
    string tf, vf, df, head;
    int    hh, mi, ss, dd, mo, yy, r;
    hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    ss = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    // days and months near the start of the calendar hit the rollback often
    r  = $urandom_range(0, 99);
    dd = (r < 25) ? 1 : (r < 35) ? 0 : (r < 40) ? $urandom_range(32, 99) : $urandom_range(1, 31);
    r  = $urandom_range(0, 99);
    mo = (r < 30) ? 1 : (r < 36) ? 0 : (r < 42) ? $urandom_range(13, 99) : $urandom_range(1, 12);
    r  = $urandom_range(0, 99);
    yy = (r < 15) ? 0 : (r < 20) ? 99 : $urandom_range(0, 99);
    tf = digit_field(hh, mi, ss);
    if ($urandom_range(0, 99) < 40) tf = {tf, $sformatf(".%02d", $urandom_range(0, 99))};
    df = digit_field(dd, mo, yy);
    r  = $urandom_range(0, 99);
    if (r < 65) vf = "A";
    else if (r < 80) vf = "V";
    else if (r < 87) vf = "";
    else if (r < 94) vf = $urandom_range(0, 1) ? "AV" : "VA";
    else vf = $sformatf("%c", $urandom_range(66, 90));
    head = ($urandom_range(0, 9) == 0) ? "$GNRMC," : "$GPRMC,";
    build_rmc(head, tf, vf, df, $urandom_range(0, 1),
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1,
              8'($urandom_range(0, 255)));
    send_line(cut_short ? $urandom_range(1, line_buf.size() - 1) : line_buf.size());
  endtask

  // reset offset of three hours, extreme bytes while hunting for R
  task automatic test_reset_offset();
    send_word(8'h00);
    send_word(8'hFF);
    send_rmc("$GPRMC,", "123519", "A", "230394", "*");
    send_rmc("$GPRMC,", "013000", "A", "150624", 8'hFF);
  endtask

  // day, month, leap year and year rollback
  task automatic test_calendar_rollback();
    send_rmc("$GPRMC,", "020000", "A", "010324", ",");
    send_rmc("$GPRMC,", "020000", "A", "010323", 8'h00);
    send_rmc("$GPRMC,", "000000", "A", "010300", "*");
    send_rmc("$GPRMC,", "000000", "A", "010105", "*");
    send_rmc("$GPRMC,", "000000", "A", "000100", "*");
    send_rmc("$GPRMC,", "000000", "A", "010000", "*");
    send_rmc("$GPRMC,", "000000", "A", "011500", "*");
    send_rmc("$GPRMC,", "000000", "A", "019999", "*");
    send_rmc("$GPRMC,", "235959", "V", "010100", "*");
  endtask

  // detours in the prefix, long, short, dotted and malformed fields
  task automatic test_field_forms();
    send_rmc("RQMQC,", "1234567890", "A", "311299123", "*");
    send_rmc("$GPRMC,", "1234", "A", "0101", "*");
    send_rmc("$GPRMC,", "12a456", "A", "1a0624", "*");
    send_rmc("$GPRMC,", "123456.789", "A", "150624", "*");
    send_rmc("$GPRMC,", "", "", "", "*");
    send_rmc("$GPRMC,", "083000", "VA", "150624", "*");
    build_rmc("$GPRMC,", "083000", "A", "150624", 1'b1, -1, -1, "0");
    send_line(line_buf.size());
  endtask

  // offset extremes, including values above the clamp
  task automatic test_offset_range();
    set_offset(5'd0);
    send_rmc("$GPRMC,", "000000", "A", "010100", "*");
    set_offset(5'd23);
    send_rmc("$GPRMC,", "220000", "A", "010100", "*");
    set_offset(5'd24);
    send_rmc("$GPRMC,", "230000", "A", "010100", "*");
    set_offset(5'd31);
    send_rmc("$GPRMC,", "000000", "A", "150699", "*");
  endtask

  // back-to-back sentences against a stalled result side until the input stalls
  task automatic test_output_stall();
    no_gaps      = 1'b1;
    hold_results = 1'b1;
    fork
      begin
        repeat (3) send_rmc("$GPRMC,", "045500", "A", "290224", ",");
      end
      begin
        do @(posedge clk); while (!(in_ch.valid && !in_ch.ready));
        hold_results = 1'b0;
      end
    join
    no_gaps = 1'b0;
    wait_for_stamps();
  endtask

  // mostly well-formed sentences with random content, some cut short, some noise
  task automatic test_random_traffic();
    int start_words;
    int n;
    int r;
    start_words = words_in_lines;
    n = 0;
    while (words_in_lines - start_words < RANDOM_WORDS) begin
      if (n % 12 == 11) set_offset(5'($urandom_range(0, 31)));
      if (n % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 78) begin
        send_random_sentence(1'b0);
      end else if (r < 90) begin
        send_random_sentence(1'b1);
      end else begin
        repeat ($urandom_range(1, 12)) send_word(8'($urandom_range(0, 255)));
      end
      n++;
    end
    no_gaps = 1'b0;
  endtask

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    walk_state      = rmc_pkg::ST_WAIT_R;
    offset_hours    = rmc_pkg::OFF_RESET;
    clear_sentence();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_offset();
    test_calendar_rollback();
    test_field_forms();
    test_offset_range();
    test_output_stall();
    test_random_traffic();
    wait_for_stamps();

    $display("covered %0d words taken (%0d inside sentences) under %0d offset settings",
             words_taken, words_in_lines, offsets_written + 1);
    $display("checked %0d results: %0d with the time shifted, %0d flagged malformed",
             stamps_checked, stamps_shifted, stamps_malformed);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
